// ----- src/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared types, command codes, sequencer phases and tick timings.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned TimeoutWidth = 12;

  // Reset value of the acknowledge timeout register, in ticks.
  localparam logic [TimeoutWidth-1:0] AckTimeoutReset = 12'd2500;

  // Tick counts are loaded as duration minus one.
  localparam logic [TimeoutWidth-1:0] WaitStart = 12'd3;
  localparam logic [TimeoutWidth-1:0] WaitStop  = 12'd3;
  localparam logic [TimeoutWidth-1:0] WaitTwo   = 12'd1;
  localparam logic [TimeoutWidth-1:0] WaitOne   = 12'd0;

  localparam logic [2:0] BitLast = 3'd7;

  typedef enum logic [2:0] {
    REQ_NONE  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_WR_SET  = 4'd5,
    PH_WR_HI   = 4'd6,
    PH_WR_LO   = 4'd7,
    PH_WA_REL  = 4'd8,
    PH_WA_HI   = 4'd9,
    PH_WA_POLL = 4'd10,
    PH_RD_LO   = 4'd11,
    PH_RD_HI   = 4'd12,
    PH_AK_LO   = 4'd13,
    PH_AK_HI   = 4'd14
  } phase_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
    logic       cmd_rejected;
  } out_item_t;

endpackage

// ----- src/i2cm_in_reg.sv -----
// ----------------------------------------------------------------------------
// I2C master input register
// Holds one tick item until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2cm_in_reg import i2cm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  // A held item that is not consumed this cycle blocks the next transfer.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- src/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// I2C master sequencer core
// Phase state machine that advances by one tick per consumed item and
// computes the pin levels and status shown after that tick.
// ----------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  in_item_t                item_i,
  input  logic [TimeoutWidth-1:0] ack_timeout_i,
  output out_item_t               result_o
);

  phase_e                  phase_q, phase_d, enter_ph;
  logic [2:0]              bit_q, bit_d;
  logic [7:0]              shift_q, shift_d;
  logic [TimeoutWidth-1:0] wait_q, wait_d;
  logic                    scl_q, scl_d;
  logic                    sda_q, sda_d;
  logic [7:0]              rx_q, rx_d;
  logic                    nack_q, nack_d;
  logic                    ackc_q, ackc_d;
  logic                    enter_en;
  logic                    done;
  logic                    rejected;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= '0;
      shift_q <= '0;
      wait_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      rx_q    <= '0;
      nack_q  <= 1'b0;
      ackc_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      rx_q    <= rx_d;
      nack_q  <= nack_d;
      ackc_q  <= ackc_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    wait_d   = wait_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    rx_d     = rx_q;
    nack_d   = nack_q;
    ackc_d   = ackc_q;
    done     = 1'b0;
    rejected = 1'b0;
    enter_en = 1'b0;
    enter_ph = PH_IDLE;

    if (phase_q == PH_IDLE) begin
      // Codes outside the command set count as no command.
      unique case (item_i.req_type)
        REQ_START: begin
          bit_d    = '0;
          enter_en = 1'b1;
          enter_ph = PH_ST_A;
        end
        REQ_STOP: begin
          bit_d    = '0;
          enter_en = 1'b1;
          enter_ph = PH_SP_A;
        end
        REQ_WRITE: begin
          bit_d    = '0;
          shift_d  = item_i.tx_byte;
          nack_d   = 1'b0;
          enter_en = 1'b1;
          enter_ph = PH_WR_SET;
        end
        REQ_READ: begin
          bit_d    = '0;
          shift_d  = '0;
          ackc_d   = item_i.ack_after_read;
          enter_en = 1'b1;
          enter_ph = PH_RD_LO;
        end
        default: begin
        end
      endcase
    end else begin
      rejected = (item_i.req_type != REQ_NONE);
      if (phase_q == PH_WA_POLL) begin
        if (!item_i.sda_level) begin
          scl_d   = 1'b0;
          nack_d  = 1'b0;
          phase_d = PH_IDLE;
          wait_d  = '0;
          done    = 1'b1;
        end else if (wait_q >= ack_timeout_i) begin
          // No acknowledge in time: close the bus with a stop.
          nack_d   = 1'b1;
          enter_en = 1'b1;
          enter_ph = PH_SP_A;
        end else begin
          wait_d = wait_q + 1'b1;
        end
      end else if (wait_q != '0) begin
        wait_d = wait_q - 1'b1;
      end else begin
        unique case (phase_q)
          PH_ST_A: begin
            enter_en = 1'b1;
            enter_ph = PH_ST_B;
          end
          PH_ST_B: begin
            scl_d   = 1'b0;
            phase_d = PH_IDLE;
            wait_d  = '0;
            done    = 1'b1;
          end
          PH_SP_A: begin
            enter_en = 1'b1;
            enter_ph = PH_SP_B;
          end
          PH_SP_B: begin
            phase_d = PH_IDLE;
            wait_d  = '0;
            done    = 1'b1;
          end
          PH_WR_SET: begin
            enter_en = 1'b1;
            enter_ph = PH_WR_HI;
          end
          PH_WR_HI: begin
            enter_en = 1'b1;
            enter_ph = PH_WR_LO;
          end
          PH_WR_LO: begin
            enter_en = 1'b1;
            if (bit_q != BitLast) begin
              bit_d    = bit_q + 1'b1;
              shift_d  = {shift_q[6:0], 1'b0};
              enter_ph = PH_WR_SET;
            end else begin
              enter_ph = PH_WA_REL;
            end
          end
          PH_WA_REL: begin
            enter_en = 1'b1;
            enter_ph = PH_WA_HI;
          end
          PH_WA_HI: begin
            phase_d = PH_WA_POLL;
            wait_d  = '0;
          end
          PH_RD_LO: begin
            enter_en = 1'b1;
            enter_ph = PH_RD_HI;
          end
          PH_RD_HI: begin
            enter_en = 1'b1;
            if (bit_q != BitLast) begin
              bit_d    = bit_q + 1'b1;
              enter_ph = PH_RD_LO;
            end else begin
              rx_d     = shift_q;
              enter_ph = PH_AK_LO;
            end
          end
          PH_AK_LO: begin
            enter_en = 1'b1;
            enter_ph = PH_AK_HI;
          end
          PH_AK_HI: begin
            scl_d   = 1'b0;
            phase_d = PH_IDLE;
            wait_d  = '0;
            done    = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
            wait_d  = '0;
          end
        endcase
      end
    end

    // Entering a phase sets its pins and loads its duration. This runs after
    // the shift register update above, so a new write bit sees the shifted byte.
    if (enter_en) begin
      phase_d = enter_ph;
      unique case (enter_ph)
        PH_ST_A: begin
          scl_d  = 1'b1;
          sda_d  = 1'b1;
          wait_d = WaitStart;
        end
        PH_ST_B: begin
          sda_d  = 1'b0;
          wait_d = WaitStart;
        end
        PH_SP_A: begin
          scl_d  = 1'b0;
          sda_d  = 1'b0;
          wait_d = WaitStop;
        end
        PH_SP_B: begin
          scl_d  = 1'b1;
          sda_d  = 1'b1;
          wait_d = WaitStop;
        end
        PH_WR_SET: begin
          scl_d  = 1'b0;
          sda_d  = shift_d[7];
          wait_d = WaitTwo;
        end
        PH_WR_HI: begin
          scl_d  = 1'b1;
          wait_d = WaitTwo;
        end
        PH_WR_LO: begin
          scl_d  = 1'b0;
          wait_d = WaitTwo;
        end
        PH_WA_REL: begin
          sda_d  = 1'b1;
          wait_d = WaitOne;
        end
        PH_WA_HI: begin
          scl_d  = 1'b1;
          wait_d = WaitOne;
        end
        PH_RD_LO: begin
          scl_d  = 1'b0;
          sda_d  = 1'b1;
          wait_d = WaitTwo;
        end
        PH_RD_HI: begin
          // The data bit is sampled on the tick SCL rises.
          scl_d   = 1'b1;
          shift_d = {shift_d[6:0], item_i.sda_level};
          wait_d  = WaitOne;
        end
        PH_AK_LO: begin
          scl_d  = 1'b0;
          sda_d  = !ackc_d;
          wait_d = WaitTwo;
        end
        PH_AK_HI: begin
          scl_d  = 1'b1;
          wait_d = WaitTwo;
        end
        default: begin
          phase_d = PH_IDLE;
          wait_d  = WaitOne;
        end
      endcase
    end
  end

  assign result_o.scl_level    = scl_d;
  assign result_o.sda_release  = sda_d;
  assign result_o.busy_res     = (phase_d != PH_IDLE);
  assign result_o.done_res     = done;
  assign result_o.rx_byte      = rx_d;
  assign result_o.ack_missing  = nack_d;
  assign result_o.cmd_rejected = rejected;

endmodule

// ----- src/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Drives SCL and SDA for start, stop, byte write with acknowledge polling and
// byte read, advancing one timebase tick per transfer on the input channel.
//
//   Channel  Handshake               Payload
//   input    in_valid_i/in_stall_o   in_item_i (in_item_t), one tick
//   result   out_valid_o/out_stall_i out_item_o (out_item_t), one per tick
//   config   cfg_we_i                cfg_wdata_i, acknowledge timeout
//
// A tick accepted into the input register is stepped through the sequencer
// logic, which moves its result into the output register; a tick can enter
// every cycle while the result side is not stalled. The phase state machine
// updates once per accepted tick.
// Reset returns the bus pins to released and the timeout to 2500 ticks.
// A stalled result holds the sequencer, and the input stalls only while its
// register holds a tick that cannot move on.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer import i2cm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_item_t               out_item_o,
  input  logic                    cfg_we_i,
  input  logic [TimeoutWidth-1:0] cfg_wdata_i
);

  logic                    held_valid;
  in_item_t                held_item;
  logic                    step;
  logic                    out_free;
  out_item_t               result;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_item_q;
  logic [TimeoutWidth-1:0] ack_timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= AckTimeoutReset;
    end else if (cfg_we_i) begin
      ack_timeout_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = held_valid && out_free;

  i2cm_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .take_i     (step),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  i2cm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (held_item),
    .ack_timeout_i (ack_timeout_q),
    .result_o      (result)
  );

  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A completed command always leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res)
    else $error("done result reports busy");

  // The sequencer never overwrites a result that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> !(out_valid_q && out_stall_i))
    else $error("sequencer stepped into a stalled output register");

  // The input side only stalls while a tick is held and the output is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> held_valid && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked output");

  // A pending tick moves into the output stage when the output is free.
  a_step_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid && out_free |=> out_valid_q)
    else $error("free output did not take a pending tick");

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Feeds timebase ticks carrying start, stop, write and read commands and the
// sampled SDA level, predicts every pin result with an internal sequencer
// model and checks each result transfer field by field. Covers directed
// corner cases, acknowledge timeouts, a long output hold-off and random
// command traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  import i2cm_pkg::*;

  localparam int          CycleLimit  = 500_000;
  localparam int          HoldCycles  = 300;
  localparam int          NeverAck    = 1 << 30;
  localparam int          SdaRandom   = 2;
  localparam logic [2:0]  ReqCodeMax  = 3'd7;
  localparam logic [2:0]  ReqFirstBad = REQ_READ + 3'd1;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  in_item_t                in_item_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  out_item_t               out_item_o;
  logic                    cfg_we_i    = 1'b0;
  logic [TimeoutWidth-1:0] cfg_wdata_i = '0;

  i2c_master_bit_sequencer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Sequencer state as predicted from the accepted ticks.
  logic [TimeoutWidth-1:0] pred_timeout = AckTimeoutReset;
  phase_e                  pred_phase   = PH_IDLE;
  logic [3:0]              pred_bit     = '0;
  logic [7:0]              pred_shift   = '0;
  logic [TimeoutWidth-1:0] pred_wait    = '0;
  logic                    pred_scl     = 1'b1;
  logic                    pred_sda     = 1'b1;
  logic [7:0]              pred_rx      = '0;
  logic                    pred_nack    = 1'b0;
  logic                    pred_ack_sel = 1'b0;

  out_item_t pin_results_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int ticks_sent = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycle_cnt = 0;

  function automatic void enter_phase(phase_e ph, logic sda_in);
    logic [TimeoutWidth-1:0] dur;
    dur = 12'd1;
    pred_phase = ph;
    case (ph)
      PH_ST_A: begin
        pred_scl = 1'b1; pred_sda = 1'b1; dur = 12'd4;
      end
      PH_ST_B: begin
        pred_sda = 1'b0; dur = 12'd4;
      end
      PH_SP_A: begin
        pred_scl = 1'b0; pred_sda = 1'b0; dur = 12'd4;
      end
      PH_SP_B: begin
        pred_scl = 1'b1; pred_sda = 1'b1; dur = 12'd4;
      end
      PH_WR_SET: begin
        pred_scl = 1'b0; pred_sda = pred_shift[7]; dur = 12'd2;
      end
      PH_WR_HI: begin
        pred_scl = 1'b1; dur = 12'd2;
      end
      PH_WR_LO: begin
        pred_scl = 1'b0; dur = 12'd2;
      end
      PH_WA_REL: pred_sda = 1'b1;
      PH_WA_HI: pred_scl = 1'b1;
      PH_WA_POLL: ;
      PH_RD_LO: begin
        pred_scl = 1'b0; pred_sda = 1'b1; dur = 12'd2;
      end
      PH_RD_HI: begin
        // Read data is sampled on the tick that SCL rises.
        pred_scl = 1'b1;
        pred_shift = {pred_shift[6:0], sda_in};
      end
      PH_AK_LO: begin
        pred_scl = 1'b0; pred_sda = ~pred_ack_sel; dur = 12'd2;
      end
      PH_AK_HI: begin
        pred_scl = 1'b1; dur = 12'd2;
      end
      default: pred_phase = PH_IDLE;
    endcase
    pred_wait = dur - 12'd1;
  endfunction

  // The current phase has run its full length; returns 1 when the command ends.
  function automatic bit advance_phase(logic sda_in);
    bit done;
    done = 1'b0;
    case (pred_phase)
      PH_ST_A: enter_phase(PH_ST_B, sda_in);
      PH_ST_B: begin
        pred_scl = 1'b0; done = 1'b1;
      end
      PH_SP_A: enter_phase(PH_SP_B, sda_in);
      PH_SP_B: done = 1'b1;
      PH_WR_SET: enter_phase(PH_WR_HI, sda_in);
      PH_WR_HI: enter_phase(PH_WR_LO, sda_in);
      PH_WR_LO: begin
        if (pred_bit < 4'd7) begin
          pred_bit = pred_bit + 4'd1;
          pred_shift = pred_shift << 1;
          enter_phase(PH_WR_SET, sda_in);
        end else begin
          enter_phase(PH_WA_REL, sda_in);
        end
      end
      PH_WA_REL: enter_phase(PH_WA_HI, sda_in);
      PH_WA_HI: begin
        pred_phase = PH_WA_POLL; pred_wait = '0;
      end
      PH_RD_LO: enter_phase(PH_RD_HI, sda_in);
      PH_RD_HI: begin
        if (pred_bit < 4'd7) begin
          pred_bit = pred_bit + 4'd1;
          enter_phase(PH_RD_LO, sda_in);
        end else begin
          pred_rx = pred_shift;
          enter_phase(PH_AK_LO, sda_in);
        end
      end
      PH_AK_LO: enter_phase(PH_AK_HI, sda_in);
      PH_AK_HI: begin
        pred_scl = 1'b0; done = 1'b1;
      end
      default: begin
        pred_phase = PH_IDLE; pred_wait = '0;
      end
    endcase
    if (done) begin
      pred_phase = PH_IDLE;
      pred_wait = '0;
    end
    return done;
  endfunction

  function automatic out_item_t predict_pins(in_item_t it);
    out_item_t res;
    bit done;
    bit rejected;
    done = 1'b0;
    rejected = 1'b0;
    if (pred_phase == PH_IDLE) begin
      if (it.req_type inside {REQ_START, REQ_STOP, REQ_WRITE, REQ_READ}) pred_bit = '0;
      case (it.req_type)
        REQ_START: enter_phase(PH_ST_A, it.sda_level);
        REQ_STOP: enter_phase(PH_SP_A, it.sda_level);
        REQ_WRITE: begin
          pred_shift = it.tx_byte;
          pred_nack = 1'b0;
          enter_phase(PH_WR_SET, it.sda_level);
        end
        REQ_READ: begin
          pred_shift = '0;
          pred_ack_sel = it.ack_after_read;
          enter_phase(PH_RD_LO, it.sda_level);
        end
        default: ;
      endcase
    end else begin
      rejected = (it.req_type != REQ_NONE);
      if (pred_phase == PH_WA_POLL) begin
        if (!it.sda_level) begin
          pred_scl = 1'b0;
          pred_nack = 1'b0;
          pred_phase = PH_IDLE;
          pred_wait = '0;
          done = 1'b1;
        end else if (pred_wait >= pred_timeout) begin
          // No acknowledge in time: abort through a stop sequence.
          pred_nack = 1'b1;
          enter_phase(PH_SP_A, it.sda_level);
        end else begin
          pred_wait = pred_wait + 12'd1;
        end
      end else if (pred_wait != '0) begin
        pred_wait = pred_wait - 12'd1;
      end else begin
        done = advance_phase(it.sda_level);
      end
    end
    res.scl_level    = pred_scl;
    res.sda_release  = pred_sda;
    res.busy_res     = (pred_phase != PH_IDLE);
    res.done_res     = done;
    res.rx_byte      = pred_rx;
    res.ack_missing  = pred_nack;
    res.cmd_rejected = rejected;
    return res;
  endfunction

  function automatic in_item_t random_tick();
    in_item_t it;
    it.req_type       = 3'($urandom_range(REQ_NONE, ReqCodeMax));
    it.tx_byte        = 8'($urandom);
    it.ack_after_read = 1'($urandom);
    it.sda_level      = 1'($urandom);
    return it;
  endfunction

  // Offers one tick after a random gap and records its prediction once taken.
  task automatic send_tick(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pin_results_q.push_back(predict_pins(it));
    ticks_sent++;
  endtask

  // Issues one command and keeps ticking until the sequencer is idle again.
  // The slave acknowledges after ack_delay high polls; other ticks carry
  // sda_fill, or random levels.
  task automatic run_command(input req_e req, input logic [7:0] tx, input logic ack_rd,
                             input int ack_delay, input int sda_fill, input int noise_pct);
    in_item_t it;
    int polls;
    polls = 0;
    it = random_tick();
    it.req_type = req;
    it.tx_byte = tx;
    it.ack_after_read = ack_rd;
    send_tick(it);
    while (pred_phase != PH_IDLE) begin
      it = random_tick();
      it.req_type = REQ_NONE;
      if (sda_fill != SdaRandom) it.sda_level = sda_fill[0];
      if (pred_phase == PH_WA_POLL) begin
        it.sda_level = (polls < ack_delay);
        polls++;
      end
      if ($urandom_range(99) < noise_pct) it.req_type = 3'($urandom_range(REQ_START, ReqCodeMax));
      send_tick(it);
    end
  endtask

  task automatic write_ack_timeout(input logic [TimeoutWidth-1:0] ticks);
    int saved_idle;
    in_item_t it;
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    while (pred_phase != PH_IDLE) begin
      it = random_tick();
      it.req_type = REQ_NONE;
      send_tick(it);
    end
    send_idle_pct = saved_idle;
    in_valid_i <= 1'b0;
    while (pin_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= ticks;
    pred_timeout = ticks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_basic_commands();
    in_item_t it;
    run_command(REQ_START, 8'h00, 1'b0, 0, SdaRandom, 0);
    run_command(REQ_WRITE, 8'hFF, 1'b0, 0, SdaRandom, 0);
    run_command(REQ_WRITE, 8'h00, 1'b1, 3, SdaRandom, 0);
    run_command(REQ_WRITE, 8'hA5, 1'b0, 1, SdaRandom, 0);
    // After an acknowledge the master must keep SDA released through these idle ticks.
    for (int i = 0; i < 3; i++) begin
      it = random_tick();
      it.req_type = REQ_NONE;
      send_tick(it);
    end
    run_command(REQ_READ, 8'hFF, 1'b1, 0, 1, 0);
    run_command(REQ_READ, 8'h00, 1'b0, 0, 0, 0);
    run_command(REQ_READ, 8'h5A, 1'b1, 0, SdaRandom, 0);
    run_command(REQ_STOP, 8'h00, 1'b0, 0, SdaRandom, 0);
    // Unknown codes while idle are ignored without a rejection flag.
    for (int c = ReqFirstBad; c <= ReqCodeMax; c++) begin
      it = random_tick();
      it.req_type = 3'(c);
      send_tick(it);
    end
  endtask

  task automatic test_busy_rejection();
    // A command on every busy tick, the completing tick included.
    run_command(REQ_START, 8'h00, 1'b0, 0, SdaRandom, 100);
    run_command(REQ_WRITE, 8'h3C, 1'b0, 2, SdaRandom, 100);
    run_command(REQ_READ, 8'h00, 1'b1, 0, SdaRandom, 100);
    run_command(REQ_STOP, 8'h00, 1'b0, 0, SdaRandom, 100);
  endtask

  task automatic test_ack_timeout();
    // A zero timeout aborts on the first high poll. A timeout of one tolerates
    // one high poll, and a write acknowledged after it clears the flag again.
    write_ack_timeout(12'd0);
    run_command(REQ_WRITE, 8'h12, 1'b0, NeverAck, SdaRandom, 0);
    write_ack_timeout(12'd1);
    run_command(REQ_WRITE, 8'h78, 1'b0, 2, SdaRandom, 0);
    run_command(REQ_WRITE, 8'h56, 1'b0, 1, SdaRandom, 0);
  endtask

  task automatic test_input_backpressure();
    write_ack_timeout(12'd4);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs++;
    run_command(REQ_START, 8'h00, 1'b0, 0, SdaRandom, 0);
    run_command(REQ_WRITE, 8'hC3, 1'b0, 2, SdaRandom, 0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [TimeoutWidth-1:0] tmo, input int tick_goal);
    int first_tick;
    int ack_delay;
    write_ack_timeout(tmo);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < tick_goal) begin
      if ($urandom_range(99) < 12) begin
        send_tick(random_tick());
      end else begin
        case ($urandom_range(3))
          0: ack_delay = 0;
          1: ack_delay = $urandom_range(int'(tmo));
          2: ack_delay = int'(tmo);
          default: ack_delay = NeverAck;
        endcase
        run_command(req_e'(3'($urandom_range(REQ_START, REQ_READ))), 8'($urandom),
                    1'($urandom), ack_delay, SdaRandom, 3);
      end
    end
  endtask

  // Output side: random stalls plus one long hold-off.
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_pins
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pin_results_q.size() == 0) begin
        if (mismatches < 10) $display("result %0d arrived with none expected", results_seen);
        mismatches++;
      end else begin
        want = pin_results_q.pop_front();
        if (out_item_o.scl_level !== want.scl_level ||
            out_item_o.sda_release !== want.sda_release ||
            out_item_o.busy_res !== want.busy_res ||
            out_item_o.done_res !== want.done_res ||
            out_item_o.rx_byte !== want.rx_byte ||
            out_item_o.ack_missing !== want.ack_missing ||
            out_item_o.cmd_rejected !== want.cmd_rejected) begin
          if (mismatches < 10) begin
            $display("result %0d: expected scl=%b sda=%b busy=%b done=%b rx=%h nack=%b rej=%b",
                     results_seen, want.scl_level, want.sda_release, want.busy_res,
                     want.done_res, want.rx_byte, want.ack_missing, want.cmd_rejected);
            $display("result %0d:      got scl=%b sda=%b busy=%b done=%b rx=%h nack=%b rej=%b",
                     results_seen, out_item_o.scl_level, out_item_o.sda_release,
                     out_item_o.busy_res, out_item_o.done_res, out_item_o.rx_byte,
                     out_item_o.ack_missing, out_item_o.cmd_rejected);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_commands();
    test_busy_rejection();
    test_ack_timeout();
    test_input_backpressure();
    test_random_traffic(0, 0, 12'd5, 30);
    test_random_traffic(72, 0, 12'd1, 30);
    test_random_traffic(0, 72, 12'd20, 30);
    test_random_traffic(17, 17, 12'd3, 30);

    in_valid_i <= 1'b0;
    while (pin_results_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
